// ----- rtl/core/rtwh_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtwh_pkg: shared types and constants of the radix-4 twiddle heap generator
// Payload structs, status codes, decode control struct and the elaboration
// function that builds the quarter-wave cosine ROM contents.
// ----------------------------------------------------------------------------
package rtwh_pkg;

  // Output sample width (Q1.15 at 16 bits)
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned POS_BITS    = 11;
  localparam int unsigned LEN_BITS    = 3;
  localparam logic [LEN_BITS-1:0] SIZE_LOG4_RESET = 3'd6;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_BEYOND = 2'd1;
  localparam logic [1:0] STATUS_QZERO  = 2'd2;

  localparam logic [63:0] Q60_ONE = 64'h1000_0000_0000_0000;
  localparam logic [63:0] PI_Q60  = 64'h3243_F6A8_885A_308D;

  typedef struct packed {
    logic [1:0]          quadrant;
    logic                inverse;
    logic [POS_BITS-1:0] heap_position;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] twiddle_real;
    logic signed [SAMPLE_BITS-1:0] twiddle_imag;
    logic [1:0]                    status;
  } out_t;

  // decode results that ride alongside the ROM read
  typedef struct packed {
    logic [1:0] status;
    logic [1:0] sect;
    logic       inverse;
  } ctrl_t;

  // floor(a*b / 2^sh), elaboration use only
  function automatic logic [63:0] rtwh_mul_shift(input logic [63:0] a,
                                                 input logic [63:0] b,
                                                 input int unsigned sh);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return 64'(p >> sh);
  endfunction

  // floor(num / den) by restoring long division, elaboration use only
  function automatic logic [63:0] rtwh_div(input logic [63:0] num,
                                           input logic [63:0] den);
    logic [64:0] part;
    logic [63:0] quo;
    part = '0;
    quo  = '0;
    for (int b = 63; b >= 0; b--) begin
      part = {part[63:0], num[b]};
      if (part >= {1'b0, den}) begin
        part   = part - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // cos(2*pi*idx/4^max_log4) in Q1.(SAMPLE_BITS-1), Taylor series in Q4.60
  function automatic logic [SAMPLE_BITS-2:0] rtwh_cos_entry(input int unsigned idx,
                                                            input int unsigned max_log4);
    logic [63:0] quarter;
    logic [63:0] i;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] d;
    logic [63:0] sum;
    logic [63:0] v;
    logic [63:0] maxv;
    int unsigned drop;
    quarter = 64'd1 << (2 * max_log4 - 2);
    i       = 64'(idx);
    drop    = 60 - (SAMPLE_BITS - 1);
    if (i > quarter) begin
      i = quarter;
    end
    if (i <= (quarter >> 1)) begin
      x = rtwh_mul_shift(PI_Q60, i, 2 * max_log4 - 1);
      t = Q60_ONE;
      d = 64'd1;
    end else begin
      x = rtwh_mul_shift(PI_Q60, quarter - i, 2 * max_log4 - 1);
      t = x;
      d = 64'd2;
    end
    x2  = rtwh_mul_shift(x, x, 60);
    sum = t;
    for (int n = 0; n < 12; n++) begin
      t = rtwh_div(rtwh_mul_shift(t, x2, 60), d * (d + 64'd1));
      if (n % 2 == 1) begin
        sum = sum + t;
      end else begin
        sum = sum - t;
      end
      d = d + 64'd2;
    end
    v    = (sum + (64'd1 << (drop - 1))) >> drop;
    maxv = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
    if (v > maxv) begin
      v = maxv;
    end
    return v[SAMPLE_BITS-2:0];
  endfunction

endpackage

// ----- rtl/core/radix4_twiddle_heap_generator.sv -----
// A result shows on out_valid after its input transaction has passed the input
//   register, the ROM read register and the output register; out_stall may hold it.
// Throughput: one transaction per cycle unless out_stall backs up the pipeline,
//   set by the combinational angle decode feeding both read ports of the cosine ROM in the same cycle.
// Reset: rst_n is synchronous, clears all pipeline valids and sets size_log4 = 6.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix4_twiddle_heap_generator: radix-4 FFT twiddle from heap position
// Three-register pipeline: decode the heap position into a ROM angle, read
// the quarter-wave cosine ROM, then fold sector and direction into the sign.
// ----------------------------------------------------------------------------
module radix4_twiddle_heap_generator #(
  parameter int unsigned MAX_LOG4 = 6
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  rtwh_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output rtwh_pkg::out_t                  out_data,
  input  logic                            cfg_we,
  input  logic [rtwh_pkg::LEN_BITS-1:0]   cfg_wdata
);

  localparam int unsigned SB = rtwh_pkg::SAMPLE_BITS;
  localparam int unsigned AW = $clog2(4**(MAX_LOG4-1)+1);
  localparam logic [3:0]  MAX_L4 = 4'(MAX_LOG4);
  localparam logic [rtwh_pkg::LEN_BITS-1:0] MIN_LEN = 3'd2;
  localparam logic [SB-1:0] MOST_NEG = {1'b1, {(SB-1){1'b0}}};

  localparam logic [1:0] SECT_Q0 = 2'd0;
  localparam logic [1:0] SECT_Q1 = 2'd1;
  localparam logic [1:0] SECT_Q2 = 2'd2;

  logic [rtwh_pkg::LEN_BITS-1:0] size_log4_r, size_log4_nxt;
  logic [rtwh_pkg::LEN_BITS-1:0] len;

  logic            v1_r, v1_nxt;
  logic            v2_r, v2_nxt;
  logic            v3_r, v3_nxt;
  rtwh_pkg::in_t   item1_r;
  rtwh_pkg::ctrl_t ctrl_dec;
  rtwh_pkg::ctrl_t ctrl2_r;
  rtwh_pkg::out_t  out_r, out_nxt;
  logic [AW-1:0]   cos_addr;
  logic [AW-1:0]   sin_addr;
  logic [SB-2:0]   cos_mag;
  logic [SB-2:0]   sin_mag;
  logic            en1, en2, en3;

  // --- configuration ---
  assign size_log4_nxt = cfg_we ? cfg_wdata : size_log4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_log4_r <= rtwh_pkg::SIZE_LOG4_RESET;
    end else begin
      size_log4_r <= size_log4_nxt;
    end
  end

  always_comb begin
    if (size_log4_r < MIN_LEN) begin
      len = MIN_LEN;
    end else if ({1'b0, size_log4_r} > MAX_L4) begin
      len = rtwh_pkg::LEN_BITS'(MAX_LOG4);
    end else begin
      len = size_log4_r;
    end
  end

  // --- flow control: each stage loads when empty or draining ---
  assign en3      = !v3_r || !out_stall;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_stall = !en1;

  assign v1_nxt = en1 ? in_valid : v1_r;
  assign v2_nxt = en2 ? v1_r : v2_r;
  assign v3_nxt = en3 ? v2_r : v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  // --- stage 1: input register ---
  always_ff @(posedge clk) begin
    if (en1) begin
      item1_r <= in_data;
    end
  end

  rtwh_angle_decode #(
    .MAX_LOG4 (MAX_LOG4)
  ) u_decode (
    .item     (item1_r),
    .len      (len),
    .ctrl     (ctrl_dec),
    .cos_addr (cos_addr),
    .sin_addr (sin_addr)
  );

  // --- stage 2: ROM read ---
  rtwh_cos_rom #(
    .MAX_LOG4 (MAX_LOG4)
  ) u_rom (
    .clk        (clk),
    .rd_en      (en2),
    .cos_addr   (cos_addr),
    .sin_addr   (sin_addr),
    .cos_data_r (cos_mag),
    .sin_data_r (sin_mag)
  );

  always_ff @(posedge clk) begin
    if (en2) begin
      ctrl2_r <= ctrl_dec;
    end
  end

  // --- stage 3: sector fold and direction sign ---
  always_comb begin
    logic signed [SB-1:0] cr;
    logic signed [SB-1:0] sr;
    logic signed [SB-1:0] c;
    logic signed [SB-1:0] s;
    cr = signed'({1'b0, cos_mag});
    sr = signed'({1'b0, sin_mag});
    case (ctrl2_r.sect)
      SECT_Q0: begin
        c = cr;
        s = sr;
      end
      SECT_Q1: begin
        c = -sr;
        s = cr;
      end
      SECT_Q2: begin
        c = -cr;
        s = -sr;
      end
      default: begin
        c = sr;
        s = -cr;
      end
    endcase
    if (!ctrl2_r.inverse) begin
      s = -s;
    end
    out_nxt.status = ctrl2_r.status;
    if (ctrl2_r.status == rtwh_pkg::STATUS_OK) begin
      out_nxt.twiddle_real = c;
      out_nxt.twiddle_imag = s;
    end else begin
      out_nxt.twiddle_real = '0;
      out_nxt.twiddle_imag = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_data  = out_r;

  // --- assertions ---
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != rtwh_pkg::STATUS_OK |->
      out_data.twiddle_real == '0 && out_data.twiddle_imag == '0)
    else $error("error transaction carries nonzero twiddle");

  a_no_most_neg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.twiddle_real != MOST_NEG && out_data.twiddle_imag != MOST_NEG)
    else $error("twiddle reached most negative code");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> v1_r && v2_r && v3_r && out_stall)
    else $error("input stalled with a free pipeline slot");

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> v1_r)
    else $error("accepted transaction lost at input register");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> ctrl2_r.status == rtwh_pkg::STATUS_OK ||
             ctrl2_r.status == rtwh_pkg::STATUS_BEYOND ||
             ctrl2_r.status == rtwh_pkg::STATUS_QZERO)
    else $error("illegal status code in pipeline");

endmodule

// ----- rtl/core/rtwh_angle_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtwh_angle_decode: heap position to ROM addresses
// Finds the stage of a heap position, forms the angle index on the ROM grid,
// splits it into an octant-free sector and the two quarter-wave addresses.
// ----------------------------------------------------------------------------
module rtwh_angle_decode #(
  parameter int unsigned MAX_LOG4 = 6
) (
  input  rtwh_pkg::in_t                         item,
  input  logic [rtwh_pkg::LEN_BITS-1:0]         len,
  output rtwh_pkg::ctrl_t                       ctrl,
  output logic [$clog2(4**(MAX_LOG4-1)+1)-1:0]  cos_addr,
  output logic [$clog2(4**(MAX_LOG4-1)+1)-1:0]  sin_addr
);

  localparam int unsigned NUM_STAGES = MAX_LOG4 - 1;
  localparam int unsigned AWID       = 2 * MAX_LOG4;      // full-circle angle
  localparam int unsigned QB         = 2 * MAX_LOG4 - 2;  // quarter-wave index
  localparam int unsigned AW         = $clog2(4**(MAX_LOG4-1)+1);
  localparam int unsigned CW = (AWID > rtwh_pkg::POS_BITS) ? AWID : rtwh_pkg::POS_BITS;
  localparam logic [AW-1:0] QUARTER = AW'(4**(MAX_LOG4-1));

  logic [CW-1:0]         pos_ext;
  logic [NUM_STAGES-1:0] stage_hit;
  logic [NUM_STAGES-1:0] stage_on;
  logic [AWID-1:0]       stage_angle [NUM_STAGES];
  logic                  found;
  logic [AWID-1:0]       angle;
  logic [QB-1:0]         rem;

  assign pos_ext = CW'(item.heap_position);

  // stage s holds 4^(s+1) entries; stride folds into a shift on the ROM grid
  for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
    localparam int unsigned STAGE_BASE = ((4**(s+1)) - 4) / 3;
    localparam int unsigned STAGE_END  = ((4**(s+2)) - 4) / 3;
    localparam int unsigned SHIFT      = 2 * (MAX_LOG4 - 2 - s);
    logic [CW-1:0]   offset;
    logic [AWID-1:0] scaled;
    assign stage_hit[s]   = pos_ext < CW'(STAGE_END);
    assign stage_on[s]    = {1'b0, len} >= 4'(s + 2);
    assign offset         = pos_ext - CW'(STAGE_BASE);
    assign scaled         = AWID'(item.quadrant) * AWID'(offset);
    assign stage_angle[s] = scaled << SHIFT;
  end

  // lowest matching stage wins
  always_comb begin
    found = 1'b0;
    angle = '0;
    for (int i = NUM_STAGES - 1; i >= 0; i--) begin
      if (stage_hit[i] && stage_on[i]) begin
        found = 1'b1;
        angle = stage_angle[i];
      end
    end
  end

  assign rem      = angle[QB-1:0];
  assign cos_addr = AW'(rem);
  assign sin_addr = QUARTER - AW'(rem);

  always_comb begin
    ctrl.sect    = angle[AWID-1 -: 2];
    ctrl.inverse = item.inverse;
    if (item.quadrant == 2'd0) begin
      ctrl.status = rtwh_pkg::STATUS_QZERO;
    end else if (!found) begin
      ctrl.status = rtwh_pkg::STATUS_BEYOND;
    end else begin
      ctrl.status = rtwh_pkg::STATUS_OK;
    end
  end

endmodule

// ----- rtl/core/rtwh_cos_rom.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtwh_cos_rom: quarter-wave cosine ROM, two registered read ports
// Entry i is cos(2*pi*i/4^MAX_LOG4) for i = 0 .. 4^MAX_LOG4/4, unsigned
// Q1.(SAMPLE_BITS-1) magnitude. Contents are computed at elaboration.
// ----------------------------------------------------------------------------
module rtwh_cos_rom #(
  parameter int unsigned MAX_LOG4 = 6
) (
  input  logic                                     clk,
  input  logic                                     rd_en,
  input  logic [$clog2(4**(MAX_LOG4-1)+1)-1:0]     cos_addr,
  input  logic [$clog2(4**(MAX_LOG4-1)+1)-1:0]     sin_addr,
  output logic [rtwh_pkg::SAMPLE_BITS-2:0]         cos_data_r,
  output logic [rtwh_pkg::SAMPLE_BITS-2:0]         sin_data_r
);

  localparam int unsigned DEPTH = 4**(MAX_LOG4-1) + 1;
  localparam int unsigned EW    = rtwh_pkg::SAMPLE_BITS - 1;

  logic [EW-1:0] rom_tbl [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_entry
    localparam logic [EW-1:0] VAL = rtwh_pkg::rtwh_cos_entry(i, MAX_LOG4);
    assign rom_tbl[i] = VAL;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      cos_data_r <= rom_tbl[cos_addr];
      sin_data_r <= rom_tbl[sin_addr];
    end
  end

endmodule
